/* design/assert_macros.svh */
// Assertion macros used by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("%m");
`define ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error("%m");
`else
`define ASSERT_CLK(label, cond)
`define ASSERT_IMPL(label, pre, post)
`endif
`endif

/* design/swmc_pkg.sv */
`default_nettype none
package swmc_pkg;
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_COST,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

/* design/sliding_window_median_cost.sv */
// Channel | Direction | Handshake     | Payload
// config  | in        | valid / ready | cfg_data (7 bits)
// in      | in        | valid / stall | sample
// out     | out       | valid / stall | median, cost
//
// Each sample passes through the states in order: on accept the row of cells is
// updated in place, then ST_SUM rotates the row past the end adder to form the
// half sums, ST_COST registers the median and cost, ST_OUT returns to idle.
// Reset sets the window length to one and clears the fill count and pointer.
// While an earlier word is held by out_stall, the cost cycle waits and the
// input stays stalled until that cycle completes.
`default_nettype none
`include "assert_macros.svh"
module sliding_window_median_cost #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [6:0]              cfg_data,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire [SAMPLE_BITS-1:0]  sample,
    output logic                   out_valid,
    input  wire                    out_stall,
    output logic [15:0]            median,
    output logic [21:0]            cost
);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = SAMPLE_BITS + CW;

    logic [6:0]            wlen_reg;
    logic [CW-1:0]         k;
    logic [CW-1:0]         fill_reg;
    logic [IW-1:0]         optr_reg;
    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] old_v_reg;
    wire  [SAMPLE_BITS-1:0] row_val [MAX_WINDOW];
    wire  [SAMPLE_BITS-1:0] comp_val [MAX_WINDOW];
    wire  [MAX_WINDOW-1:0]  comp_gt;
    swmc_pkg::state_t      st_reg, st_next;
    logic [CW-1:0]         cnt_reg;
    logic [SW-1:0]         lo_reg, hi_reg;
    logic [SAMPLE_BITS-1:0] med_reg;
    logic                  emit_reg;
    logic [15:0]           med_out_reg;
    logic [21:0]           cost_out_reg;
    logic                  ov_reg;

    always_comb
    begin
        if (wlen_reg == 7'd0) k = CW'(1);
        else if ({25'd0, wlen_reg} > MAX_WINDOW) k = CW'(MAX_WINDOW);
        else k = CW'(wlen_reg);
    end

    logic            accept, full, sum_phase, out_free;
    logic [IW-1:0]   optr_eff;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (st_reg != swmc_pkg::ST_IDLE);
    assign cfg_ready = (st_reg == swmc_pkg::ST_IDLE);
    assign full      = (fill_reg >= k);
    assign optr_eff  = ({1'b0, optr_reg} >= (IW+1)'(k)) ? '0 : optr_reg;
    assign sum_phase = (st_reg == swmc_pkg::ST_SUM);
    assign out_free  = !ov_reg || !out_stall;

    // The oldest sample is registered ahead of its use; the row is busy long before
    // the next word can arrive.
    always_ff @(posedge clk)
    begin
        if (accept) ring[optr_eff] <= sample;
        old_v_reg <= ring[optr_eff];
    end

    // Locate the removed copy; once the window is full, every slot at or above it,
    // the top slot apart, takes its upper neighbor's value before the insert.
    logic [MAX_WINDOW-1:0] eqv, act, rem_at, rem_below, take_upper;
    logic [CW-1:0] n_after;
    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++) begin
            act[j] = (CW'(j) < fill_reg) && (CW'(j) < k);
            eqv[j] = act[j] && (row_val[j] == old_v_reg);
        end
        // First matching copy, or the top entry as a guard.
        rem_below[0] = 1'b0;
        rem_at[0]    = eqv[0];
        for (int j = 1; j < MAX_WINDOW; j++) begin
            rem_below[j] = rem_below[j-1] || rem_at[j-1];
            rem_at[j]    = eqv[j] && !rem_below[j];
        end
        if (!(|eqv)) begin
            for (int j = 0; j < MAX_WINDOW; j++) begin
                rem_at[j]    = full && (CW'(j) == k - CW'(1));
                rem_below[j] = 1'b0;
            end
        end
        n_after = full ? (k - CW'(1)) : fill_reg;
        for (int j = 0; j < MAX_WINDOW; j++)
            take_upper[j] = full && (rem_at[j] || rem_below[j]) && (j + 1 < MAX_WINDOW);
    end

    for (genvar j = 0; j < MAX_WINDOW; j++)
    begin : g_row
        swmc_cell #(
            .W(SAMPLE_BITS)
        ) u_cell (
            .clk(clk),
            .load(accept),
            .shift(sum_phase),
            .take_upper(take_upper[j]),
            .in_range(CW'(j) < n_after),
            .ins_range(CW'(j) <= n_after),
            .sample(sample),
            .upper_val(row_val[(j + 1) % MAX_WINDOW]),
            .lower_comp_val((j > 0) ? comp_val[(j > 0) ? j - 1 : 0] : '0),
            .lower_comp_gt((j > 0) ? comp_gt[(j > 0) ? j - 1 : 0] : 1'b0),
            .val(row_val[j]),
            .comp_val(comp_val[j]),
            .comp_gt(comp_gt[j])
        );
    end

    logic [CW-1:0] mid;
    assign mid = (k - CW'(1)) >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wlen_reg <= 7'd1;
            fill_reg <= '0;
            optr_reg <= '0;
            st_reg   <= swmc_pkg::ST_IDLE;
            cnt_reg  <= '0;
            emit_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_valid && cfg_ready) begin
                wlen_reg <= cfg_data;
                fill_reg <= '0;
                optr_reg <= '0;
            end else if (accept) begin
                if (!full) fill_reg <= fill_reg + CW'(1);
                optr_reg <= ({1'b0, optr_eff} + 1'b1 >= (IW+1)'(k)) ? '0 : optr_eff + 1'b1;
                emit_reg <= full || (fill_reg + CW'(1) >= k);
                cnt_reg  <= '0;
            end else if (sum_phase) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (st_reg == swmc_pkg::ST_COST && out_free) ov_reg <= emit_reg;
            else if (!out_stall) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            lo_reg <= '0;
            hi_reg <= '0;
        end else if (sum_phase) begin
            if (cnt_reg < k) begin
                if (cnt_reg <= mid) lo_reg <= lo_reg + SW'(row_val[0]);
                else hi_reg <= hi_reg + SW'(row_val[0]);
            end
            if (cnt_reg == mid) med_reg <= row_val[0];
        end else if (st_reg == swmc_pkg::ST_COST && out_free) begin
            med_out_reg  <= 16'(med_reg);
            cost_out_reg <= 22'(SW'((mid + CW'(1)) * SW'(med_reg)) - lo_reg + hi_reg
                                - SW'((k - mid - CW'(1)) * SW'(med_reg)));
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            swmc_pkg::ST_IDLE: if (accept) st_next = swmc_pkg::ST_SUM;
            swmc_pkg::ST_SUM:
                if (cnt_reg == CW'(MAX_WINDOW - 1)) st_next = swmc_pkg::ST_COST;
            swmc_pkg::ST_COST: if (out_free) st_next = swmc_pkg::ST_OUT;
            swmc_pkg::ST_OUT: st_next = swmc_pkg::ST_IDLE;
            default: st_next = swmc_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign median    = med_out_reg;
    assign cost      = cost_out_reg;

    `ASSERT_CLK(a_fill_bound, fill_reg <= CW'(MAX_WINDOW))
    `ASSERT_IMPL(a_busy_no_cfg, st_reg != swmc_pkg::ST_IDLE, !cfg_ready)
    `ASSERT_IMPL(a_hold, out_valid && out_stall, ##1 out_valid)
    `ASSERT_IMPL(a_hold_data, out_valid && out_stall, ##1 $stable({median, cost}))
endmodule
`default_nettype wire

/* design/swmc_cell.sv */
`default_nettype none
// One slot of the sorted row. On a new word the slot first closes the gap left
// by the removed sample, then keeps its value, takes its lower neighbor's value
// or takes the new sample, so the row stays sorted. During the sum pass the row
// rotates down by one slot per cycle.
module swmc_cell #(
    parameter int W = 16
) (
    input  wire          clk,
    input  wire          load,
    input  wire          shift,
    input  wire          take_upper,     // removed copy sits at or below this slot
    input  wire          in_range,       // slot holds a sample after the removal
    input  wire          ins_range,      // slot holds a sample after the insert
    input  wire [W-1:0]  sample,
    input  wire [W-1:0]  upper_val,
    input  wire [W-1:0]  lower_comp_val,
    input  wire          lower_comp_gt,
    output logic [W-1:0] val,
    output logic [W-1:0] comp_val,
    output logic         comp_gt
);
    logic [W-1:0] val_reg, val_next;

    assign val = val_reg;

    always_comb
    begin
        comp_val = take_upper ? upper_val : val_reg;
        comp_gt  = in_range && (comp_val > sample);
        if (in_range && !comp_gt)
            val_next = comp_val;
        else if (lower_comp_gt && ins_range)
            val_next = lower_comp_val;
        else if (ins_range)
            val_next = sample;
        else
            val_next = comp_val;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            val_reg <= val_next;
        else if (shift)
            val_reg <= upper_val;
    end
endmodule
`default_nettype wire
